// ===== hw/rtl/mbc_pkg.sv =====
package mbc_pkg;

  // Widths fixed by the interface.
  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 14;
  localparam int DIM_BITS = 13;
  localparam int LIMIT_BITS = 14;
  localparam int CFG_DATA_BITS = 14;
  localparam int CFG_INDEX_BITS = 2;

  // Default fraction width of the fixed-point words.
  localparam int FRAC_BITS_DEFAULT = 26;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = 2'd2;

  // Register values after reset.
  localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET = 13'd1024;
  localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd1024;
  localparam logic [LIMIT_BITS-1:0] ITERATION_LIMIT_RESET = 14'd10000;

  // One request: a pixel position.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  // One result: iterations done and the escape flag.
  typedef struct packed {
    logic [COUNT_BITS-1:0] iteration_count;
    logic                  escaped;
  } result_t;

endpackage

// ===== hw/rtl/mbc_divider.sv =====
module mbc_divider #(
  parameter int NUM_BITS = 40,
  parameter int DEN_BITS = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic [NUM_BITS-1:0] quotient,
  output logic                done
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [DEN_BITS-1:0] rem;
  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] den;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // Restoring division: one quotient bit per cycle, numerator bits shift in from the top.
  assign trial = {rem, quo[NUM_BITS-1]};
  assign diff = trial - {1'b0, den};
  assign fits = (trial >= {1'b0, den});
  assign quotient = quo;

  // Step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        cnt <= CNT_BITS'(NUM_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        done <= (cnt == CNT_BITS'(1));
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= numer;
      den <= denom;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/mbc_mac.sv =====
module mbc_mac #(
  parameter int A_BITS = 28,
  parameter int B_BITS = 14
) (
  input  logic                  clk,
  input  logic [A_BITS-1:0]     a,
  input  logic [B_BITS-1:0]     b,
  input  logic                  upper,
  output logic [2*A_BITS-1:0]   acc
);

  localparam int ACC_BITS = 2 * A_BITS;

  logic [A_BITS+B_BITS-1:0] prod;
  logic [ACC_BITS-1:0]      part;

  // One narrow multiply per cycle; a full product takes a lower and an upper half of b.
  assign prod = a * b;
  assign part = upper ? (ACC_BITS'(prod) << B_BITS) : ACC_BITS'(prod);

  // The lower half loads the accumulator, the upper half adds onto it.
  always_ff @(posedge clk) begin
    acc <= (upper ? acc : '0) + part;
  end

endmodule

// ===== hw/rtl/mandelbrot_escape_counter.sv =====
// Throughput: one request at a time; the next start is taken once busy is low.
// Coordinate mapping runs on a bit-serial divider, each iteration on a shared half-width
// multiply-accumulate unit. The receiver cannot stall: done is a one-cycle strobe.
// Reset is synchronous and active high; it returns to idle and reloads the register defaults.
module mandelbrot_escape_counter #(
  parameter int FRAC_BITS = mbc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mbc_pkg::pixel_t                   pixel,
  output logic                              done,
  output mbc_pkg::result_t                  result,
  input  logic                              wr_en,
  input  logic [mbc_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [mbc_pkg::CFG_DATA_BITS-1:0]  wr_data
);

  localparam int CB = mbc_pkg::COORD_BITS;
  localparam int DB = mbc_pkg::DIM_BITS;
  localparam int W = FRAC_BITS + 6;
  localparam int MB = FRAC_BITS + 2;
  localparam int H = (MB + 1) / 2;
  localparam int AW = 2 * MB;
  localparam int NB = CB + FRAC_BITS + 2;
  localparam int SW = (NB + 1 > W + 3) ? NB + 1 : W + 3;
  localparam int SQ_BITS = FRAC_BITS + 3;
  localparam int SUM_BITS = SQ_BITS + 1;

  localparam logic signed [SW-1:0] WMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] WMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] CX_OFFSET = SW'(5) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] CY_OFFSET = SW'(1) << FRAC_BITS;
  localparam logic [W-1:0] TWO_FX = W'(1) << (FRAC_BITS + 1);
  localparam logic [SUM_BITS-1:0] FOUR_FX = SUM_BITS'(1) << (FRAC_BITS + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVX = 4'd1;
  localparam logic [3:0] S_DIVY = 4'd2;
  localparam logic [3:0] S_TEST = 4'd3;
  localparam logic [3:0] S_SQX0 = 4'd4;
  localparam logic [3:0] S_SQX1 = 4'd5;
  localparam logic [3:0] S_SQY0 = 4'd6;
  localparam logic [3:0] S_SQY1 = 4'd7;
  localparam logic [3:0] S_XY0 = 4'd8;
  localparam logic [3:0] S_XY1 = 4'd9;
  localparam logic [3:0] S_UPD = 4'd10;

  function automatic logic signed [W-1:0] sat_word(input logic signed [SW-1:0] v);
    if (v > WMAX) begin
      return WMAX[W-1:0];
    end else if (v < WMIN) begin
      return WMIN[W-1:0];
    end
    return v[W-1:0];
  endfunction

  logic [3:0]                      state;
  logic [DB-1:0]                   image_width;
  logic [DB-1:0]                   image_height;
  logic [mbc_pkg::LIMIT_BITS-1:0]  iteration_limit;
  logic [CB-1:0]                   row;
  logic signed [W-1:0]             cx;
  logic signed [W-1:0]             cy;
  logic signed [W-1:0]             zx;
  logic signed [W-1:0]             zy;
  logic [SQ_BITS-1:0]              sx;
  logic [SQ_BITS-1:0]              sy;
  logic [mbc_pkg::COUNT_BITS-1:0]  count;

  logic                            div_load;
  logic [NB-1:0]                   div_numer;
  logic [DB-1:0]                   div_denom;
  logic [NB-1:0]                   div_quot;
  logic                            div_done;
  logic [CB+2:0]                   x_times7;
  logic signed [SW-1:0]            q_ext;

  logic [W-1:0]                    magx;
  logic [W-1:0]                    magy;
  logic [MB-1:0]                   op_a;
  logic [MB-1:0]                   op_b;
  logic [H-1:0]                    mac_b;
  logic                            mac_upper;
  logic [AW-1:0]                   acc;
  logic [SQ_BITS-1:0]              acc_sq;
  logic [SUM_BITS-1:0]             mag_sum;
  logic signed [AW:0]              xy_full;
  logic signed [AW:0]              xy_shift;
  logic signed [SW-1:0]            xy_ext;
  logic signed [SW-1:0]            sx_ext;
  logic signed [SW-1:0]            sy_ext;
  logic signed [SW-1:0]            nx_sum;
  logic signed [SW-1:0]            ny_sum;

  assign busy = (state != S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= mbc_pkg::IMAGE_WIDTH_RESET;
      image_height <= mbc_pkg::IMAGE_HEIGHT_RESET;
      iteration_limit <= mbc_pkg::ITERATION_LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        mbc_pkg::REG_IMAGE_WIDTH: image_width <= wr_data[DB-1:0];
        mbc_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data[DB-1:0];
        mbc_pkg::REG_ITERATION_LIMIT: iteration_limit <= wr_data[mbc_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Mapping numerators: 3.5*x and 2*y scaled to the fraction, divided by the picture size.
  // A zero size divides as one.
  assign x_times7 = {pixel.pixel_x, 3'b000} - {3'b000, pixel.pixel_x};
  assign div_load = (start && !busy) || (state == S_DIVX && div_done);
  assign div_numer = (state == S_IDLE) ? {x_times7, {(FRAC_BITS-1){1'b0}}}
                                       : {1'b0, row, {(FRAC_BITS+1){1'b0}}};
  assign div_denom = (state == S_IDLE)
                     ? ((image_width == '0) ? DB'(1) : image_width)
                     : ((image_height == '0) ? DB'(1) : image_height);
  assign q_ext = SW'(div_quot);

  mbc_divider #(
    .NUM_BITS(NB),
    .DEN_BITS(DB)
  ) u_divider (
    .clk(clk),
    .rst(rst),
    .load(div_load),
    .numer(div_numer),
    .denom(div_denom),
    .quotient(div_quot),
    .done(div_done)
  );

  // Magnitudes of z; the escape test keeps them within MB bits before any multiply.
  assign magx = zx[W-1] ? ~zx + 1'b1 : zx;
  assign magy = zy[W-1] ? ~zy + 1'b1 : zy;

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    case (state)
      S_SQY0, S_SQY1: begin
        op_a = magy[MB-1:0];
        op_b = magy[MB-1:0];
      end
      S_XY0, S_XY1: begin
        op_a = magx[MB-1:0];
        op_b = magy[MB-1:0];
      end
      default: begin
        op_a = magx[MB-1:0];
        op_b = magx[MB-1:0];
      end
    endcase
  end

  assign mac_upper = (state == S_SQX1) || (state == S_SQY1) || (state == S_XY1);
  assign mac_b = mac_upper ? H'(op_b[MB-1:H]) : op_b[H-1:0];

  mbc_mac #(
    .A_BITS(MB),
    .B_BITS(H)
  ) u_mac (
    .clk(clk),
    .a(op_a),
    .b(mac_b),
    .upper(mac_upper),
    .acc(acc)
  );

  // Squares shifted down by the fraction, and the |z|^2 escape test.
  assign acc_sq = acc[FRAC_BITS +: SQ_BITS];
  assign mag_sum = SUM_BITS'(sx) + SUM_BITS'(acc_sq);

  // Cross term 2*zx*zy: signed product, floor shift by one less than the fraction.
  assign xy_full = (zx[W-1] ^ zy[W-1]) ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  assign xy_shift = xy_full >>> (FRAC_BITS - 1);
  assign xy_ext = SW'(xy_shift);
  assign sx_ext = SW'(sx);
  assign sy_ext = SW'(sy);
  assign nx_sum = sx_ext - sy_ext + SW'(cx);
  assign ny_sum = xy_ext + SW'(cy);

  // Sequencer: map the pixel, then run one iteration after another until escape or the limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            row <= pixel.pixel_y;
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            cx <= sat_word(q_ext - CX_OFFSET);
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            cy <= sat_word(q_ext - CY_OFFSET);
            zx <= '0;
            zy <= '0;
            count <= '0;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (count >= iteration_limit) begin
            result.iteration_count <= count;
            result.escaped <= 1'b0;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (magx > TWO_FX || magy > TWO_FX) begin
            result.iteration_count <= count;
            result.escaped <= 1'b1;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SQX0;
          end
        end
        S_SQX0: state <= S_SQX1;
        S_SQX1: state <= S_SQY0;
        S_SQY0: begin
          sx <= acc_sq;
          state <= S_SQY1;
        end
        S_SQY1: state <= S_XY0;
        S_XY0: begin
          sy <= acc_sq;
          if (mag_sum > FOUR_FX) begin
            result.iteration_count <= count;
            result.escaped <= 1'b1;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_XY1;
          end
        end
        S_XY1: state <= S_UPD;
        S_UPD: begin
          zx <= sat_word(nx_sum);
          zy <= sat_word(ny_sum);
          count <= count + 1'b1;
          state <= S_TEST;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVX || state == S_DIVY))
    else $error("divider finished outside the mapping phase");

  // An accepted request always starts the real-axis division.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DIVX && !busy == 1'b0))
    else $error("accepted request did not start the mapping");

  // The iteration count never passes the limit while iterating.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DIVX && state != S_DIVY) |-> (count <= iteration_limit))
    else $error("iteration count passed the limit");

  // An escaped result always lies below the limit.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.escaped) |-> (result.iteration_count < iteration_limit))
    else $error("escape reported at or beyond the limit");

  // A result appears only as the sequencer returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE && $past(state) != S_IDLE))
    else $error("result strobe without a finished request");

endmodule

// ===== tb/testbench.sv =====
module testbench;

  // Fixed-point format of the block as built here.
  localparam int FRAC = mbc_pkg::FRAC_BITS_DEFAULT;
  localparam int WORD = FRAC + 6;
  localparam longint ONE_FX = longint'(1) << FRAC;
  localparam longint HALF_FX = ONE_FX >> 1;
  localparam longint WORD_MAX = (longint'(1) << (WORD - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) << (WORD - 1));

  // Field widths used for explicit casts.
  localparam int XY_BITS = mbc_pkg::COORD_BITS;
  localparam int DATA_BITS = mbc_pkg::CFG_DATA_BITS;

  // Index that names no register.
  localparam logic [mbc_pkg::CFG_INDEX_BITS-1:0] SPARE_INDEX = 2'd3;

  // Watchdog bound on the whole run, and the size of the random test phases.
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PIXELS_PER_PHASE = 10;

  typedef struct packed {
    mbc_pkg::pixel_t  px;
    mbc_pkg::result_t res;
  } escape_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  mbc_pkg::pixel_t pixel = '0;
  logic wr_en = 1'b0;
  logic [mbc_pkg::CFG_INDEX_BITS-1:0] wr_index = '0;
  logic [mbc_pkg::CFG_DATA_BITS-1:0] wr_data = '0;
  logic busy;
  logic done;
  mbc_pkg::result_t result;

  // Register copies used for prediction.
  logic [mbc_pkg::DIM_BITS-1:0] cfg_width = mbc_pkg::IMAGE_WIDTH_RESET;
  logic [mbc_pkg::DIM_BITS-1:0] cfg_height = mbc_pkg::IMAGE_HEIGHT_RESET;
  logic [mbc_pkg::LIMIT_BITS-1:0] cfg_limit = mbc_pkg::ITERATION_LIMIT_RESET;

  escape_case_t pending_escapes[$];
  int mismatches = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int escaped_seen = 0;
  int bounded_seen = 0;
  int settings_written = 0;
  int cycle_count = 0;

  mandelbrot_escape_counter dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pixel(pixel),
    .done(done),
    .result(result),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Clamp to the signed word range of the datapath.
  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint fx_abs(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Escape-time count for one pixel under the current register values.
  function automatic mbc_pkg::result_t escape_time(mbc_pkg::pixel_t p);
    longint px, py, div_w, div_h, cx, cy, zx, zy, sx, sy, nx;
    int count;
    mbc_pkg::result_t r;
    px = p.pixel_x;
    py = p.pixel_y;
    div_w = cfg_width;
    div_h = cfg_height;
    if (div_w == 0) div_w = 1;
    if (div_h == 0) div_h = 1;
    cx = clamp_word((7 * HALF_FX * px) / div_w - 5 * HALF_FX);
    cy = clamp_word((2 * ONE_FX * py) / div_h - ONE_FX);
    zx = 0;
    zy = 0;
    count = 0;
    r.escaped = 1'b0;
    while (count < cfg_limit) begin
      if (fx_abs(zx) > 2 * ONE_FX || fx_abs(zy) > 2 * ONE_FX) begin
        r.escaped = 1'b1;
        break;
      end
      sx = (zx * zx) >>> FRAC;
      sy = (zy * zy) >>> FRAC;
      if (sx + sy > 4 * ONE_FX) begin
        r.escaped = 1'b1;
        break;
      end
      nx = clamp_word(sx - sy + cx);
      zy = clamp_word(((zx * zy) >>> (FRAC - 1)) + cy);
      zx = nx;
      count++;
    end
    r.iteration_count = count[mbc_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  // Every result is compared with the oldest pixel still in flight.
  always @(posedge clk) begin : result_checker
    escape_case_t want;
    if (!rst && done) begin
      if (pending_escapes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual count %0d escaped %0b",
                 $time, result.iteration_count, result.escaped);
      end else begin
        want = pending_escapes.pop_front();
        results_checked++;
        if (result.escaped) escaped_seen++;
        else bounded_seen++;
        if (result.iteration_count !== want.res.iteration_count) begin
          mismatches++;
          $display("%0t: pixel (%0d,%0d) iteration_count expected %0d actual %0d",
                   $time, want.px.pixel_x, want.px.pixel_y,
                   want.res.iteration_count, result.iteration_count);
        end
        if (result.escaped !== want.res.escaped) begin
          mismatches++;
          $display("%0t: pixel (%0d,%0d) escaped expected %0b actual %0b",
                   $time, want.px.pixel_x, want.px.pixel_y,
                   want.res.escaped, result.escaped);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d results still awaited",
               $time, pending_escapes.size());
      $display("[mandelbrot_escape_counter] ERROR");
      $finish;
    end
  end

  // Wait until every request has produced its result and the block is free.
  task automatic drain_results();
    while (pending_escapes.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_register(logic [mbc_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [mbc_pkg::CFG_DATA_BITS-1:0] data);
    drain_results();
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      mbc_pkg::REG_IMAGE_WIDTH: cfg_width = data[mbc_pkg::DIM_BITS-1:0];
      mbc_pkg::REG_IMAGE_HEIGHT: cfg_height = data[mbc_pkg::DIM_BITS-1:0];
      mbc_pkg::REG_ITERATION_LIMIT: cfg_limit = data[mbc_pkg::LIMIT_BITS-1:0];
      default: ;
    endcase
    settings_written++;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_registers(int width, int height, int limit);
    write_register(mbc_pkg::REG_IMAGE_WIDTH, DATA_BITS'(width));
    write_register(mbc_pkg::REG_IMAGE_HEIGHT, DATA_BITS'(height));
    write_register(mbc_pkg::REG_ITERATION_LIMIT, DATA_BITS'(limit));
  endtask

  // Send one request, optionally after an idle stretch, and record its prediction.
  task automatic send_pixel(mbc_pkg::pixel_t p, int idle_pct);
    escape_case_t entry;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(120, 1)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    entry.px = p;
    entry.res = escape_time(p);
    pending_escapes.push_back(entry);
    pixels_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_xy(int x, int y);
    mbc_pkg::pixel_t p;
    p.pixel_x = XY_BITS'(x);
    p.pixel_y = XY_BITS'(y);
    send_pixel(p, 0);
  endtask

  // Mostly pixels inside the picture, some anywhere in the coordinate range.
  function automatic mbc_pkg::pixel_t random_pixel();
    mbc_pkg::pixel_t p;
    int w, h;
    w = (cfg_width == 0) ? 1 : ((cfg_width > 4096) ? 4096 : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : ((cfg_height > 4096) ? 4096 : int'(cfg_height));
    if ($urandom_range(9) < 7) begin
      p.pixel_x = XY_BITS'($urandom_range(w - 1));
      p.pixel_y = XY_BITS'($urandom_range(h - 1));
    end else begin
      p.pixel_x = XY_BITS'($urandom_range(4095));
      p.pixel_y = XY_BITS'($urandom_range(4095));
    end
    return p;
  endfunction

  function automatic int random_dimension();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return 8191;
    return $urandom_range(4096, 1);
  endfunction

  // Reset values: a corner, a pixel beyond the picture and a point that never escapes.
  task automatic test_default_config();
    send_xy(0, 0);
    send_xy(4095, 4095);
    send_xy(585, 512);
  endtask

  // Zero limit gives no iterations; one iteration; the largest limit both ways.
  task automatic test_iteration_limit_extremes();
    write_register(mbc_pkg::REG_ITERATION_LIMIT, 14'd0);
    send_xy(585, 512);
    send_xy(0, 0);
    write_register(mbc_pkg::REG_ITERATION_LIMIT, 14'd1);
    send_xy(585, 512);
    send_xy(4095, 0);
    write_register(mbc_pkg::REG_ITERATION_LIMIT, 14'd16383);
    send_xy(585, 512);
    send_xy(700, 300);
  endtask

  // A zero divisor acts as one, so most pixels saturate the mapped point.
  task automatic test_zero_dimensions();
    set_registers(0, 0, 50);
    send_xy(0, 0);
    send_xy(1, 1);
    send_xy(4095, 4095);
  endtask

  // Smallest picture size and the largest width; the width write also checks masking to 13 bits.
  task automatic test_dimension_extremes();
    set_registers(16383, 4096, 300);
    send_xy(4095, 4095);
    send_xy(0, 2048);
    send_xy(4681, 2048);
    set_registers(1, 1, 64);
    send_xy(0, 0);
    send_xy(1, 0);
    send_xy(4095, 1);
  endtask

  // A write to the spare register index must leave every register alone.
  task automatic test_unknown_register();
    set_registers(1024, 768, 200);
    write_register(SPARE_INDEX, 14'h3fff);
    send_xy(585, 384);
    send_xy(300, 700);
  endtask

  // Random phases with a fresh register setting each and varying sender idling.
  task automatic test_random_phases();
    int idle_plan[4];
    int idle_pct;
    idle_plan[0] = 0;
    idle_plan[1] = 60;
    idle_plan[2] = 0;
    idle_plan[3] = 17;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_pct = idle_plan[phase % 4];
      set_registers(random_dimension(), random_dimension(), $urandom_range(200, 1));
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        if (i == PIXELS_PER_PHASE / 2 && phase % 2 == 1) drain_results();
        send_pixel(random_pixel(), idle_pct);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_config();
    test_iteration_limit_extremes();
    test_zero_dimensions();
    test_dimension_extremes();
    test_unknown_register();
    test_random_phases();

    drain_results();
    repeat (200) @(posedge clk);

    $display("Sent %0d pixels over %0d register writes; %0d results checked.",
             pixels_sent, settings_written, results_checked);
    $display("%0d pixels escaped, %0d ran to the iteration limit, %0d mismatches.",
             escaped_seen, bounded_seen, mismatches);
    if (mismatches == 0 && pending_escapes.size() == 0) begin
      $display("[mandelbrot_escape_counter] OK");
    end else begin
      $display("[mandelbrot_escape_counter] ERROR");
    end
    $finish;
  end

endmodule

// ===== mandelbrot_escape_counter.f =====
hw/rtl/mbc_pkg.sv
hw/rtl/mbc_divider.sv
hw/rtl/mbc_mac.sv
hw/rtl/mandelbrot_escape_counter.sv
tb/testbench.sv
